// ----- src/rat_pkg.sv -----
// Shared types and codes for the range address translation table.
package rat_pkg;

  localparam int unsigned ADDR_W = 64;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_COVERED = 2'd1;
  localparam logic [1:0] ST_MISS    = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Job queue between front and back; depth is a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] logical_address;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] physical_start;
  } rat_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] physical_address;
    logic [1:0]        status;
  } rat_rsp_t;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] logical;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] physical;
    logic [ADDR_W:0]   need_end;
  } rat_job_t;

  typedef struct packed {
    logic              valid;
    rat_job_t          job;
  } rat_head_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] phys;
  } rat_entry_t;

endpackage

// ----- src/rat_front.sv -----
// Front stage: takes request beats and works out the end of the access.
module rat_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  rat_pkg::rat_req_t req,
  input  logic              q_full,
  output logic              push,
  output rat_pkg::rat_job_t job
);

  logic                      job_valid;
  logic                      accept;
  logic [rat_pkg::ADDR_W:0]  need_end;

  assign req_stall = job_valid && q_full;
  assign accept    = req_valid && !req_stall;
  assign push      = job_valid && !q_full;

  // Exact 65-bit end of the access; an add probes a single byte.
  always_comb begin
    need_end = {1'b0, req.logical_address} +
               ((req.opcode == rat_pkg::OP_XLATE) ? {1'b0, req.length}
                                                  : {{rat_pkg::ADDR_W{1'b0}}, 1'b1});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= 1'b1;
    end else if (push) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.opcode   <= req.opcode;
      job.logical  <= req.logical_address;
      job.length   <= req.length;
      job.physical <= req.physical_start;
      job.need_end <= need_end;
    end
  end

endmodule

// ----- src/rat_queue.sv -----
// Short job queue between the front and the table engine.
module rat_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rat_pkg::rat_job_t  job_in,
  output logic               full,
  input  logic               pop,
  output rat_pkg::rat_head_t head
);

  rat_pkg::rat_job_t             slots [rat_pkg::QUEUE_DEPTH];
  logic [rat_pkg::QPTR_W-1:0]    wr_ptr;
  logic [rat_pkg::QPTR_W-1:0]    rd_ptr;
  logic [rat_pkg::QCNT_W-1:0]    count;
  logic                          do_push;
  logic                          do_pop;

  assign full       = (count == rat_pkg::QCNT_W'(rat_pkg::QUEUE_DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + rat_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + rat_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + rat_pkg::QCNT_W'(1);
        2'b01:   count <= count - rat_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= job_in;
    end
  end

endmodule

// ----- src/rat_back.sv -----
// Table engine: scans the region store one entry a cycle and answers each job.
module rat_back #(
  parameter int unsigned REGION_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  rat_pkg::rat_head_t head,
  output logic               pop,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rat_pkg::rat_rsp_t  rsp
);

  localparam int unsigned IDX_W = $clog2(REGION_COUNT);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t                       state;
  rat_pkg::rat_job_t            cur;
  logic [IDX_W-1:0]             idx;
  logic                         eval_live;
  logic [IDX_W-1:0]             eval_idx;
  rat_pkg::rat_entry_t          eval_entry;
  logic                         eval_valid;
  logic                         hit_found;
  logic [rat_pkg::ADDR_W-1:0]   best_start;
  logic [rat_pkg::ADDR_W-1:0]   best_offset;
  logic                         dup_found;
  logic                         free_found;
  logic [IDX_W-1:0]             free_idx;
  logic                         identity_mode;
  logic [REGION_COUNT-1:0]      region_valid;
  rat_pkg::rat_entry_t          table_mem [REGION_COUNT];

  logic [rat_pkg::ADDR_W:0]     eval_end;
  logic                         eval_hold;
  logic                         eval_better;
  logic                         eval_dup;
  logic                         out_free;
  logic                         write_en;

  assign out_free = !rsp_valid || !rsp_stall;
  assign pop      = (state == S_IDLE) && head.valid;
  assign write_en = (state == S_FINISH) && out_free && (cur.opcode == rat_pkg::OP_ADD) &&
                    !hit_found && !dup_found && free_found;

  always_comb begin
    eval_end    = {1'b0, eval_entry.start} + {1'b0, eval_entry.size};
    eval_hold   = eval_valid && (eval_entry.start <= cur.logical) &&
                  (eval_end >= cur.need_end);
    eval_better = !hit_found || (eval_entry.start < best_start);
    eval_dup    = eval_valid && (eval_entry.start == cur.logical);
  end

  // Region store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (write_en) begin
      table_mem[free_idx] <= '{start: cur.logical, size: cur.length, phys: cur.physical};
    end
    eval_entry <= table_mem[idx];
    eval_valid <= region_valid[idx];
    eval_idx   <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      eval_live     <= 1'b0;
      region_valid  <= '0;
      identity_mode <= 1'b1;
      rsp_valid     <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      eval_live <= (state == S_SCAN);

      if (eval_live) begin
        if (eval_hold && eval_better) begin
          hit_found   <= 1'b1;
          best_start  <= eval_entry.start;
          best_offset <= eval_entry.phys - eval_entry.start;
        end
        if (eval_dup) begin
          dup_found <= 1'b1;
        end
        if (!eval_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= eval_idx;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur        <= head.job;
            idx        <= '0;
            hit_found  <= 1'b0;
            dup_found  <= 1'b0;
            free_found <= 1'b0;
            // Identity translate needs no lookup.
            if (head.job.opcode == rat_pkg::OP_XLATE && identity_mode) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          idx <= idx + IDX_W'(1);
          if (idx == IDX_W'(REGION_COUNT - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
            if (cur.opcode == rat_pkg::OP_XLATE) begin
              if (identity_mode) begin
                rsp.physical_address <= cur.logical;
                rsp.status           <= rat_pkg::ST_OK;
              end else if (hit_found) begin
                rsp.physical_address <= cur.logical + best_offset;
                rsp.status           <= rat_pkg::ST_OK;
              end else begin
                rsp.physical_address <= '0;
                rsp.status           <= rat_pkg::ST_MISS;
              end
            end else begin
              rsp.physical_address <= '0;
              if (hit_found || dup_found) begin
                rsp.status <= rat_pkg::ST_COVERED;
              end else if (!free_found) begin
                rsp.status <= rat_pkg::ST_FULL;
              end else begin
                rsp.status             <= rat_pkg::ST_OK;
                region_valid[free_idx] <= 1'b1;
                if (cur.physical != cur.logical) begin
                  identity_mode <= 1'b0;
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_identity_sticky: assert property (@(posedge clk) disable iff (rst)
    !identity_mode |=> !identity_mode)
    else $error("identity mode set again after a non-identity region");

  a_miss_not_identity: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == rat_pkg::ST_MISS) |-> !identity_mode)
    else $error("miss answered while in identity mode");

  a_free_slot_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && free_found) |-> !region_valid[free_idx])
    else $error("chosen free slot already holds a region");

  a_scan_feeds_eval: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> eval_live)
    else $error("scanned entry not evaluated");

endmodule

// ----- src/range_address_translation_table.sv -----
// Range address translation table: holds mapped regions and translates addresses.
//
// Request channel (req_valid, req_stall, req): a beat carries an opcode, a logical
// address, a length and a physical start. Opcode add inserts a region unless an
// existing region covers its start or no slot is free; opcode translate returns the
// physical address from the lowest-start region holding the whole access.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one beat per request, in
// request order, carrying the physical address and a status code.
// Path from request beat to response offered: front register, queue, one table entry
// per cycle through the single read port of the region store, then the answer; an
// identity-mode translate skips the scan and returns the logical address itself.
// The table engine works on one request at a time.
// A short queue lets the front take further beats while the table engine works.
// Reset empties the table and sets identity mode; no clearing pass is needed.
// A stalled response holds in the output register; the engine then waits, the queue
// fills, and req_stall rises once the front register is also occupied.
module range_address_translation_table #(
  parameter int unsigned REGION_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  rat_pkg::rat_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rat_pkg::rat_rsp_t rsp
);

  logic               push;
  logic               q_full;
  logic               pop;
  rat_pkg::rat_job_t  job;
  rat_pkg::rat_head_t head;

  rat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .job       (job)
  );

  rat_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (job),
    .full   (q_full),
    .pop    (pop),
    .head   (head)
  );

  rat_back #(
    .REGION_COUNT (REGION_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
